[rtl/core/blake2b_256_hash_defines.svh]
// ----------------------------------------------------------------------------
// blake2b_256_hash_defines.svh
// Assertion macros shared by the hash core files.
// ----------------------------------------------------------------------------
`ifndef BLAKE2B_256_HASH_DEFINES_SVH
`define BLAKE2B_256_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define B2B_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define B2B_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B2B_ASSERT(label, clk, rst, prop, msg)
`define B2B_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/core/b2b_pkg.sv]
// ----------------------------------------------------------------------------
// b2b_pkg
// Constants, types and helper functions for the BLAKE2b-256 core.
// ----------------------------------------------------------------------------
package b2b_pkg;

   localparam int BlockBytes  = 128;
   localparam int FillW       = 8;
   localparam int ByteIdxW    = 7;
   localparam int Rounds      = 12;
   localparam int RoundW      = 4;
   localparam int StepW       = 3;

   localparam logic [63:0] IV0 = 64'h6a09e667f3bcc908;
   localparam logic [63:0] IV1 = 64'hbb67ae8584caa73b;
   localparam logic [63:0] IV2 = 64'h3c6ef372fe94f82b;
   localparam logic [63:0] IV3 = 64'ha54ff53a5f1d36f1;
   localparam logic [63:0] IV4 = 64'h510e527fade682d1;
   localparam logic [63:0] IV5 = 64'h9b05688c2b3e6c1f;
   localparam logic [63:0] IV6 = 64'h1f83d9abfb41bd6b;
   localparam logic [63:0] IV7 = 64'h5be0cd19137e2179;
   localparam logic [63:0] ParamWord = 64'h0000000001010020;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       take_byte;   // write byte at fill position
      logic       hold_byte;   // capture input byte until the block is compressed
      logic       pad_byte;    // write zero at fill position
      logic       load;        // init working vector
      logic       final_blk;   // last-block flag for load
      logic       mix;         // run one G step
      logic       fold;        // fold working vector into chain
      logic       restart;     // return chain and counters to start
      logic       clr_fill;    // fill count to zero after a compression
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       block_full;
      logic       fill_done;   // fill count reached the block size
      logic       mix_done;    // last G step of last round issued
   } stat_type;

   function automatic logic [63:0] iv_word(input logic [2:0] i);
      logic [63:0] r;
      case (i)
         3'd0: r = IV0;
         3'd1: r = IV1;
         3'd2: r = IV2;
         3'd3: r = IV3;
         3'd4: r = IV4;
         3'd5: r = IV5;
         3'd6: r = IV6;
         default: r = IV7;
      endcase
      return r;
   endfunction

   // message word index for round r (mod 10), slot k
   function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
      logic [63:0] row;
      case (r)
         4'd0: row = 64'hfedcba9876543210;
         4'd1: row = 64'h357b20c16df984ae;
         4'd2: row = 64'h491763eadf250c8b;
         4'd3: row = 64'h8f04a562ebcd1397;
         4'd4: row = 64'hd386cb1efa427509;
         4'd5: row = 64'h91ef57d438b0a6c2;
         4'd6: row = 64'hb8293670a4def15c;
         4'd7: row = 64'ha2684f05931ce7bd;
         4'd8: row = 64'h5a417d2c803b9ef6;
         default: row = 64'h0dc3e9bf5167482a;
      endcase
      return row[k*4 +: 4];
   endfunction

endpackage

[rtl/core/b2b_ctrl.sv]
// ----------------------------------------------------------------------------
// b2b_ctrl
// Sequencer: byte intake, padding, compression steps, digest handoff.
// ----------------------------------------------------------------------------
`include "blake2b_256_hash_defines.svh"
module b2b_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_byte_present,
   input  logic                 req_last_of_message,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output b2b_pkg::cmd_type     cmd,
   input  b2b_pkg::stat_type    stat
);

   b2b_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;       // compression is the final one
   logic pend_ff, pend_in;       // held byte waits for a full-block compression
   // pending last mark carried through the full-block compression
   logic plast_ff, plast_in;
   logic req_take;

   assign req_take = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      pend_in  = pend_ff;
      case (state_ff)
         b2b_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_byte_present && stat.block_full) begin
                  // compress full block first, then store byte
                  state_in = b2b_pkg::ST_LOAD;
                  last_in  = 1'b0;
                  pend_in  = 1'b1;
               end else if (req_last_of_message) begin
                  state_in = b2b_pkg::ST_PAD;
                  last_in  = 1'b1;
               end
            end
         end
         b2b_pkg::ST_PAD: begin
            if (stat.fill_done) state_in = b2b_pkg::ST_LOAD;
         end
         b2b_pkg::ST_LOAD:  state_in = b2b_pkg::ST_ROUND;
         b2b_pkg::ST_ROUND: if (stat.mix_done) state_in = b2b_pkg::ST_FOLD;
         b2b_pkg::ST_FOLD: begin
            pend_in = 1'b0;
            if (last_ff) state_in = b2b_pkg::ST_RESP;
            else if (pend_ff && plast_ff) begin
               // stored byte carried last mark: pad and compress the final block
               state_in = b2b_pkg::ST_PAD;
               last_in  = 1'b1;
            end else state_in = b2b_pkg::ST_IDLE;
         end
         b2b_pkg::ST_RESP: if (!rsp_stall) state_in = b2b_pkg::ST_IDLE;
         default: state_in = b2b_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      plast_in   = plast_ff;
      case (state_ff)
         b2b_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_take) begin
               if (req_byte_present && !stat.block_full) cmd.take_byte = 1'b1;
               if (req_byte_present && stat.block_full) begin
                  cmd.hold_byte = 1'b1;
                  plast_in      = req_last_of_message;
               end
            end
         end
         b2b_pkg::ST_PAD:   cmd.pad_byte = ~stat.fill_done;
         b2b_pkg::ST_LOAD: begin
            cmd.load      = 1'b1;
            cmd.final_blk = last_ff;
         end
         b2b_pkg::ST_ROUND: cmd.mix = 1'b1;
         b2b_pkg::ST_FOLD: begin
            cmd.fold     = 1'b1;
            cmd.clr_fill = 1'b1;
            cmd.take_byte = pend_ff;
         end
         b2b_pkg::ST_RESP: begin
            rsp_valid   = 1'b1;
            cmd.restart = ~rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2b_pkg::ST_IDLE;
         last_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         plast_ff <= 1'b0;
      end else begin
         plast_ff <= plast_in;
         pend_ff  <= pend_in;
         state_ff <= state_in;
         last_ff  <= (state_in == b2b_pkg::ST_IDLE) ? 1'b0 : last_in;
      end
   end

   `B2B_ASSERT(a_rsp_only_resp, clock, reset, rsp_valid |-> state_ff == b2b_pkg::ST_RESP, "rsp out of state")
   `B2B_ASSERT(a_busy_stall, clock, reset, (state_ff != b2b_pkg::ST_IDLE) |-> req_stall, "took item while busy")
   `B2B_ASSERT(a_resp_final, clock, reset, (state_ff == b2b_pkg::ST_RESP) |-> last_ff, "digest without final block")
   `B2B_ASSERT(a_pad_to_load, clock, reset, (state_ff == b2b_pkg::ST_PAD && stat.fill_done) |=> state_ff == b2b_pkg::ST_LOAD, "pad did not end in load")

endmodule

[rtl/core/b2b_datapath.sv]
// ----------------------------------------------------------------------------
// b2b_datapath
// Block buffer, counters, chain value and a single G-function unit.
// ----------------------------------------------------------------------------
`include "blake2b_256_hash_defines.svh"
module b2b_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_data_byte,
   input  b2b_pkg::cmd_type     cmd,
   output b2b_pkg::stat_type    stat,
   output logic [63:0]          rsp_digest_word0,
   output logic [63:0]          rsp_digest_word1,
   output logic [63:0]          rsp_digest_word2,
   output logic [63:0]          rsp_digest_word3
);

   logic [63:0] w_ff [16];      // message block as 16 little-endian words
   logic [63:0] h_ff [8];
   logic [63:0] v_ff [16];
   logic [b2b_pkg::FillW-1:0]  fill_ff;
   logic [63:0]                count_ff;
   logic [b2b_pkg::RoundW-1:0] round_ff;
   logic [b2b_pkg::StepW-1:0]  step_ff;
   logic [7:0]                 held_ff;   // byte that arrived on a full block
   logic [b2b_pkg::ByteIdxW-1:0] widx;
   logic [3:0] ia, ib, ic, id, rsel, mx, my;
   logic [63:0] a1, d1, c1, b1, a2, d2, c2, b2;

   assign widx = fill_ff[b2b_pkg::ByteIdxW-1:0];
   assign stat.block_full = fill_ff[b2b_pkg::FillW-1];
   assign stat.fill_done  = fill_ff[b2b_pkg::FillW-1];
   assign stat.mix_done   = (round_ff == 4'(b2b_pkg::Rounds - 1)) && (step_ff == 3'd7);

   // G lane indices for the current step
   always_comb begin
      case (step_ff)
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
      rsel = (round_ff >= 4'd10) ? round_ff - 4'd10 : round_ff;
      mx = b2b_pkg::sigma(rsel, {step_ff, 1'b0});
      my = b2b_pkg::sigma(rsel, {step_ff, 1'b1});
      a1 = v_ff[ia] + v_ff[ib] + w_ff[mx];
      d1 = v_ff[id] ^ a1;  d1 = {d1[31:0], d1[63:32]};
      c1 = v_ff[ic] + d1;
      b1 = v_ff[ib] ^ c1;  b1 = {b1[23:0], b1[63:24]};
      a2 = a1 + b1 + w_ff[my];
      d2 = d1 ^ a2;        d2 = {d2[15:0], d2[63:16]};
      c2 = c1 + d2;
      b2 = b1 ^ c2;        b2 = {b2[62:0], b2[63]};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         fill_ff  <= '0;
         count_ff <= '0;
         for (int i = 0; i < 8; i++)
            h_ff[i] <= (i == 0) ? (b2b_pkg::IV0 ^ b2b_pkg::ParamWord)
                                : b2b_pkg::iv_word(3'(i));
         round_ff <= '0;
         step_ff  <= '0;
      end else begin
         if (cmd.hold_byte) held_ff <= req_data_byte;
         if (cmd.take_byte) begin
            // after a compression the byte comes from the hold register
            w_ff[widx[6:3]][{widx[2:0], 3'b000} +: 8] <=
               cmd.clr_fill ? held_ff : req_data_byte;
            fill_ff  <= (cmd.clr_fill ? 8'd0 : fill_ff) + 8'd1;
            count_ff <= count_ff + 64'd1;
         end else if (cmd.clr_fill) fill_ff <= '0;
         if (cmd.pad_byte) begin
            w_ff[widx[6:3]][{widx[2:0], 3'b000} +: 8] <= 8'h00;
            fill_ff <= fill_ff + 8'd1;
         end
         if (cmd.load) begin
            for (int i = 0; i < 8; i++) begin
               v_ff[i]   <= h_ff[i];
               v_ff[i+8] <= (i == 4) ? (b2b_pkg::IV4 ^ count_ff) :
                            (i == 6) ? (cmd.final_blk ? ~b2b_pkg::IV6 : b2b_pkg::IV6) :
                                       b2b_pkg::iv_word(3'(i));
            end
            round_ff <= '0;
            step_ff  <= '0;
         end
         if (cmd.mix) begin
            v_ff[ia] <= a2;
            v_ff[ib] <= b2;
            v_ff[ic] <= c2;
            v_ff[id] <= d2;
            step_ff  <= step_ff + 3'd1;
            if (step_ff == 3'd7) round_ff <= round_ff + 4'd1;
         end
         if (cmd.fold)
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] ^ v_ff[i] ^ v_ff[i+8];
      end
   end

   assign rsp_digest_word0 = h_ff[0];
   assign rsp_digest_word1 = h_ff[1];
   assign rsp_digest_word2 = h_ff[2];
   assign rsp_digest_word3 = h_ff[3];

   `B2B_ASSERT(a_fill_range, clock, reset, fill_ff <= 8'd128, "fill count past block")
   `B2B_ASSERT(a_no_write_full, clock, reset, (cmd.take_byte && !cmd.clr_fill) |-> !fill_ff[7], "byte into full block")
   `B2B_ASSERT(a_round_range, clock, reset, round_ff <= 4'd12, "round counter overrun")

endmodule

[rtl/core/blake2b_256_hash.sv]
// ----------------------------------------------------------------------------
// blake2b_256_hash
// Unkeyed BLAKE2b-256 over a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_stall  data_byte, byte_present, last_of_message
// rsp_      out  rsp_valid/rsp_stall  digest_word0..3 (little-endian words)
//
// A byte is written straight into the 128-byte buffer while it has room.
// A byte arriving on a full buffer is held and starts a compression: one G
// step per cycle on the shared G unit, 96 steps plus load and fold.
// A last mark pads the buffer one byte per cycle to the block end, runs
// the final compression, then holds the digest until rsp_stall is low.
// Reset is synchronous, active high; the input is stalled while busy.
// ----------------------------------------------------------------------------
module blake2b_256_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word0,
   output logic [63:0] rsp_digest_word1,
   output logic [63:0] rsp_digest_word2,
   output logic [63:0] rsp_digest_word3
);

   b2b_pkg::cmd_type  cmd;    // sequencer commands
   b2b_pkg::stat_type stat;   // datapath status

   b2b_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_byte_present    (req_byte_present),
      .req_last_of_message (req_last_of_message),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .cmd                 (cmd),
      .stat                (stat)
   );

   b2b_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_digest_word0 (rsp_digest_word0),
      .rsp_digest_word1 (rsp_digest_word1),
      .rsp_digest_word2 (rsp_digest_word2),
      .rsp_digest_word3 (rsp_digest_word3)
   );

endmodule

[verif/b2b_digest_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b2b_digest_checker
// Watches the byte and digest channels of the BLAKE2b-256 core, hashes the
// accepted bytes itself and compares each digest transfer with its own result.
// ----------------------------------------------------------------------------
module b2b_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_digest_word0,
   input  logic [63:0] rsp_digest_word1,
   input  logic [63:0] rsp_digest_word2,
   input  logic [63:0] rsp_digest_word3,
   output int          fail_count,
   output int          pending_digests,
   output int          digest_count
);

   typedef logic [63:0] word_t;
   typedef struct packed {
      word_t w3, w2, w1, w0;
   } digest_t;

   word_t      chain[8];
   logic [7:0] blk[b2b_pkg::BlockBytes];
   word_t      total_bytes;
   int         fill;
   digest_t    expected_digests[$];

   function automatic word_t rotr(word_t x, int k);
      return (x >> k) | (x << (64 - k));
   endfunction

   function automatic word_t ivw(int i);
      word_t t[8];
      t = '{b2b_pkg::IV0, b2b_pkg::IV1, b2b_pkg::IV2, b2b_pkg::IV3,
            b2b_pkg::IV4, b2b_pkg::IV5, b2b_pkg::IV6, b2b_pkg::IV7};
      return t[i];
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) chain[i] = ivw(i);
      chain[0] ^= 64'h0000000001010020;
      total_bytes = '0;
      fill = 0;
   endtask

   task automatic compress(bit last_blk);
      word_t v[16];
      word_t m[16];
      int    lanes[8][4];
      int    sched[10][16];
      int    a, b, c, d, s;
      lanes = '{'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
                '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}};
      sched = '{'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
                '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
                '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
                '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
                '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
                '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
                '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
                '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
                '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
                '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
      for (int i = 0; i < 8; i++) begin
         v[i] = chain[i];
         v[i + 8] = ivw(i);
      end
      v[12] ^= total_bytes;
      if (last_blk) v[14] = ~v[14];
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 8; j++) m[i][j*8 +: 8] = blk[i*8 + j];
      for (int r = 0; r < b2b_pkg::Rounds; r++) begin
         s = r % 10;
         for (int g = 0; g < 8; g++) begin
            a = lanes[g][0]; b = lanes[g][1]; c = lanes[g][2]; d = lanes[g][3];
            v[a] = v[a] + v[b] + m[sched[s][2*g]];
            v[d] = rotr(v[d] ^ v[a], 32);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 24);
            v[a] = v[a] + v[b] + m[sched[s][2*g + 1]];
            v[d] = rotr(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 63);
         end
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
   endtask

   task automatic absorb_transfer(logic [7:0] byt, logic present, logic last);
      digest_t dg;
      if (present) begin
         if (fill >= b2b_pkg::BlockBytes) begin
            compress(1'b0);
            fill = 0;
         end
         blk[fill] = byt;
         fill++;
         total_bytes++;
      end
      if (last) begin
         for (int i = fill; i < b2b_pkg::BlockBytes; i++) blk[i] = '0;
         compress(1'b1);
         dg.w0 = chain[0]; dg.w1 = chain[1]; dg.w2 = chain[2]; dg.w3 = chain[3];
         expected_digests.push_back(dg);
         restart_hash();
      end
   endtask

   task automatic check_word(string name, word_t exp_w, word_t act_w);
      if (exp_w !== act_w) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_w, act_w);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      digest_count = 0;
      pending_digests = 0;
      restart_hash();
   end

   // Handshakes are looked at mid-cycle: all signals are settled and hold the
   // values that the next rising edge will take.
   always @(negedge clock) begin
      digest_t e;
      if (!reset) begin
         if (req_valid && !req_stall)
            absorb_transfer(req_data_byte, req_byte_present, req_last_of_message);
         if (rsp_valid && !rsp_stall) begin
            if (expected_digests.size() == 0) begin
               $error("digest transfer with none expected");
               fail_count++;
            end else begin
               e = expected_digests.pop_front();
               check_word("digest_word0", e.w0, rsp_digest_word0);
               check_word("digest_word1", e.w1, rsp_digest_word1);
               check_word("digest_word2", e.w2, rsp_digest_word2);
               check_word("digest_word3", e.w3, rsp_digest_word3);
               digest_count++;
            end
         end
      end
      pending_digests = expected_digests.size();
   end
endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed byte-stream test of the BLAKE2b-256 core; the checker
// module predicts every digest and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_last_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [63:0] rsp_digest_word0, rsp_digest_word1, rsp_digest_word2, rsp_digest_word3;
   int          fail_count, pending_digests, digest_count;
   int          sent_items = 0;
   bit          drain_done = 1'b0;
   bit          rsp_seen = 1'b0;   // rsp_valid just before the next rising edge
   bit          rsp_held = 1'b1;   // rsp_stall just before the next rising edge
   int          rsp_wait = 0;      // cycles still to hold the waiting digest

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   blake2b_256_hash u_dut (.*);

   b2b_digest_checker u_chk (.*);

   // Drive one transfer, wait for acceptance, then an optional random gap.
   // valid stays high from one transfer into the next when no gap is drawn.
   // Acceptance is judged mid-cycle, where req_stall is settled.
   task automatic send_item(logic [7:0] b, logic p, logic l);
      int gap;
      bit took;
      req_valid           <= 1'b1;
      req_data_byte       <= b;
      req_byte_present    <= p;
      req_last_of_message <= l;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      sent_items++;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;   // bursts with no idling
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A message of n bytes with random content; occasional idle items mixed in.
   // The last byte carries the last mark unless n is zero.
   task automatic send_message(int n, bit idles);
      for (int i = 0; i < n; i++) begin
         if (idles && $urandom_range(0, 15) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, i == n - 1);
      end
      if (n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   always @(negedge clock) begin
      rsp_seen = rsp_valid;
      rsp_held = rsp_stall;
   end

   // Receiver stall: a random hold drawn anew for each digest.
   always @(posedge clock) begin
      int w;
      if (reset || (rsp_seen && !rsp_held)) begin
         w = $urandom_range(0, 7);
         rsp_wait  <= w;
         rsp_stall <= (w != 0);
      end else if (rsp_seen && rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end
   end

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, byte extremes, idle items, block boundaries
      send_message(0, 0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h55, 1'b0, 1'b1);
      send_message(128, 0);
      send_message(129, 0);
      // a full block then a bare last mark: no byte, so no extra compression
      for (int i = 0; i < 128; i++) send_item(8'haa, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);

      // hold off until every digest is back
      req_valid <= 1'b0;
      while (pending_digests != 0) @(posedge clock);

      // random: mostly short messages, a few long ones of 120 to 300 bytes
      while (sent_items < 1950) begin
         if ($urandom_range(0, 19) == 0) n = $urandom_range(120, 300);
         else n = $urandom_range(0, 40);
         send_message(n, 1);
      end
      req_valid <= 1'b0;

      while (pending_digests != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Sent %0d byte-stream transfers, checked %0d digests", sent_items,
               digest_count);
      drain_done = 1'b1;
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // watchdog: worst case is far below this
   initial begin
      #4000000;
      if (!drain_done) begin
         $display("Regression FAIL");
         $finish;
      end
   end
endmodule
